### sv/wdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdc_pkg
// Shared types and constants for the windowed dip counter.
// ----------------------------------------------------------------------------
package wdc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIP_DROP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_RISE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMA_WEIGHT   = 2'd3;

    localparam logic [12:0] HISTORY_SIZE_RESET = 13'd1000;
    localparam logic [15:0] DIP_DROP_RESET     = 16'd3640;
    localparam logic [15:0] RECOVER_RISE_RESET = 16'd1092;
    localparam logic [20:0] EMA_WEIGHT_RESET   = 21'd1049;

    localparam logic [20:0] WEIGHT_ONE = 21'h100000;
    localparam logic [52:0] ROUND_HALF = 53'h80000;
    localparam logic [47:0] TOTAL_MAX  = {48{1'b1}};

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage
`default_nettype wire

### sv/wdc_end_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdc_end_queue
// Queue of dip end slots held in a synchronous memory with a registered
// head read.
// ----------------------------------------------------------------------------
module wdc_end_queue
    import wdc_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire queue_ctrl_t       ctrl,
    input  wire logic [DATA_W-1:0] push_data,
    output logic      [DATA_W-1:0] head_data,
    output queue_stat_t            stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        if (ctrl.pop)
        begin
            head_next = (32'(head_reg) + 32'd1 >= 32'(DEPTH)) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next = (32'(tail_reg) + 32'd1 >= 32'(DEPTH)) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        head_data <= mem[head_reg];
    end

    assign stat.empty = (used_reg == '0);
    assign stat.full  = (32'(used_reg) >= 32'(DEPTH));

endmodule
`default_nettype wire

### sv/wdc_ema.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdc_ema
// Moving average update in Q12.20; the sample term is registered when the
// word is taken and the average term is formed combinationally from it.
// ----------------------------------------------------------------------------
module wdc_ema
    import wdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic [11:0] sample_value,
    input  wire logic [20:0] ema_weight,
    input  wire logic        seed,
    input  wire logic [11:0] sample_held,
    input  wire logic [31:0] avg_value,
    output logic      [31:0] avg_new
);

    logic [20:0] weight_eff;
    logic [32:0] sample_term_reg;
    logic [20:0] keep_weight_reg;
    logic [52:0] avg_term;
    logic [52:0] avg_rounded;
    logic [33:0] avg_sum;

    assign weight_eff = (ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_term_reg <= 33'({21'b0, sample_value} * {12'b0, weight_eff});
            keep_weight_reg <= WEIGHT_ONE - weight_eff;
        end
    end

    always_comb
    begin
        avg_term    = {21'b0, avg_value} * {32'b0, keep_weight_reg};
        avg_rounded = avg_term + ROUND_HALF;
        avg_sum     = {1'b0, avg_rounded[52:20]} + {1'b0, sample_term_reg};
        avg_new     = seed ? {sample_held, 20'b0} : avg_sum[31:0];
    end

endmodule
`default_nettype wire

### sv/windowed_dip_counter_ema.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_dip_counter_ema
// Light dip detector with a moving average and a windowed dip count.
// A result is held in the busy state after its sample word is taken and is
// presented when it commits, later while the previous result is still
// stalled at the output. No new sample word is taken while busy; the busy
// state waits for the registered head read of the end queue memory.
// Reset: rst_n clears all counters, the average and the queue pointers at
// once; the queue memory itself is not cleared.
// ----------------------------------------------------------------------------
module windowed_dip_counter_ema
    import wdc_pkg::*;
#(
    parameter int WINDOW_MAX      = 4096,
    parameter int END_QUEUE_DEPTH = 2048
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [11:0]            sample_value,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [$clog2(END_QUEUE_DEPTH+1)-1:0] dip_count,
    output logic [31:0]                 average_value,
    output logic                        dip_started,
    output logic                        in_dip,
    output logic [$clog2(WINDOW_MAX+1)-1:0] samples_in_window,
    output logic [47:0]                 samples_total
);

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W  = $clog2(END_QUEUE_DEPTH + 1);

    logic [12:0] history_size_reg;
    logic [15:0] dip_drop_reg;
    logic [15:0] recover_rise_reg;
    logic [20:0] ema_weight_reg;

    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [11:0]       sample_reg;
    logic [31:0]       avg_reg;
    logic [31:0]       avg_next;
    logic              waiting_reg;
    logic              waiting_next;
    logic [31:0]       saved_avg_reg;
    logic [31:0]       saved_avg_next;
    logic [CNT_W-1:0]  open_dips_reg;
    logic [CNT_W-1:0]  open_dips_next;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] write_slot_next;
    logic [FILL_W-1:0] window_fill_reg;
    logic [FILL_W-1:0] window_fill_next;
    logic [47:0]       total_reg;
    logic [47:0]       total_next;
    logic              started_reg;
    logic              started_next;

    logic              accept;
    logic              commit;
    logic              first;
    logic [FILL_W-1:0] ring_len;
    logic [FILL_W-1:0] slot_plus;
    logic [FILL_W:0]   fill_plus;
    logic [CNT_W-1:0]  open_after;
    logic signed [33:0] drop_diff;
    logic signed [33:0] rise_diff;
    logic              opening;
    logic              closing;
    logic [31:0]       avg_new;
    logic [SLOT_W-1:0] head_slot;
    queue_ctrl_t       qctrl;
    queue_stat_t       qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_size_reg <= HISTORY_SIZE_RESET;
            dip_drop_reg     <= DIP_DROP_RESET;
            recover_rise_reg <= RECOVER_RISE_RESET;
            ema_weight_reg   <= EMA_WEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HISTORY_SIZE: history_size_reg <= cfg_data[12:0];
                CFG_DIP_DROP:     dip_drop_reg     <= cfg_data[15:0];
                CFG_RECOVER_RISE: recover_rise_reg <= cfg_data[15:0];
                CFG_EMA_WEIGHT:   ema_weight_reg   <= cfg_data[20:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign commit   = busy_reg && (!out_valid_reg || !out_stall);
    assign first    = (total_reg == '0);

    always_comb
    begin
        if (history_size_reg == '0)
        begin
            ring_len = FILL_W'(1);
        end
        else if (32'(history_size_reg) > 32'(WINDOW_MAX))
        begin
            ring_len = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            ring_len = FILL_W'(history_size_reg);
        end
    end

    always_comb
    begin
        slot_plus        = FILL_W'(write_slot_reg) + 1'b1;
        write_slot_next  = (slot_plus >= ring_len) ? '0 : slot_plus[SLOT_W-1:0];
        fill_plus        = {1'b0, window_fill_reg} + 1'b1;
        window_fill_next = (fill_plus > {1'b0, ring_len}) ? ring_len : fill_plus[FILL_W-1:0];
        total_next       = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;

        qctrl.pop  = !qstat.empty && (head_slot == write_slot_next);
        open_after = (qctrl.pop && open_dips_reg != '0) ? open_dips_reg - 1'b1 : open_dips_reg;

        drop_diff = $signed({2'b0, avg_reg}) - $signed({2'b0, sample_reg, 20'b0});
        rise_diff = $signed({2'b0, sample_reg, 20'b0}) - $signed({2'b0, saved_avg_reg});
        opening   = !waiting_reg && (drop_diff >= $signed({2'b0, dip_drop_reg, 16'b0}));
        closing   = waiting_reg && (rise_diff >= $signed({2'b0, recover_rise_reg, 16'b0}));

        qctrl.push     = closing && (!qstat.full || qctrl.pop);
        waiting_next   = opening ? 1'b1 : (closing ? 1'b0 : waiting_reg);
        saved_avg_next = opening ? avg_reg : saved_avg_reg;
        started_next   = opening;
        if (opening && 32'(open_after) < 32'(END_QUEUE_DEPTH))
        begin
            open_dips_next = open_after + 1'b1;
        end
        else
        begin
            open_dips_next = open_after;
        end
        avg_next = avg_new;

        qctrl.pop  = qctrl.pop && commit;
        qctrl.push = qctrl.push && commit;
    end

    always_comb
    begin
        busy_next      = accept ? 1'b1 : (commit ? 1'b0 : busy_reg);
        out_valid_next = commit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            avg_reg         <= '0;
            waiting_reg     <= 1'b0;
            saved_avg_reg   <= '0;
            open_dips_reg   <= '0;
            write_slot_reg  <= '0;
            window_fill_reg <= '0;
            total_reg       <= '0;
            started_reg     <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                avg_reg         <= avg_next;
                waiting_reg     <= waiting_next;
                saved_avg_reg   <= saved_avg_next;
                open_dips_reg   <= open_dips_next;
                write_slot_reg  <= write_slot_next;
                window_fill_reg <= window_fill_next;
                total_reg       <= total_next;
                started_reg     <= started_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_value;
        end
    end

    wdc_ema u_ema
    (
        .clk          (clk),
        .load         (accept),
        .sample_value (sample_value),
        .ema_weight   (ema_weight_reg),
        .seed         (first),
        .sample_held  (sample_reg),
        .avg_value    (avg_reg),
        .avg_new      (avg_new)
    );

    wdc_end_queue #(
        .DEPTH  (END_QUEUE_DEPTH),
        .DATA_W (SLOT_W)
    ) u_end_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctrl),
        .push_data (write_slot_next),
        .head_data (head_slot),
        .stat      (qstat)
    );

    assign out_valid         = out_valid_reg;
    assign dip_count         = open_dips_reg;
    assign average_value     = avg_reg;
    assign dip_started       = started_reg;
    assign in_dip            = waiting_reg;
    assign samples_in_window = window_fill_reg;
    assign samples_total     = total_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted word did not enter the compute cycle");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qctrl.pop |-> !qstat.empty)
        else $error("end queue popped while empty");

    a_start_in_dip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && started_reg |-> waiting_reg)
        else $error("dip start reported without an open dip");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(open_dips_reg) <= 32'(END_QUEUE_DEPTH))
        else $error("dip count above its limit");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && !busy_reg)
        else $error("finished word not presented");

endmodule
`default_nettype wire

### dv/windowed_dip_counter_ema_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_dip_counter_ema_test
// Self-checking bench for the light dip counter. A directed table comes first.
// Random phases with shaped dip episodes follow, and one phase stops the
// retirement of queued dip ends so that dips pile up in the counter and the
// end queue. Every result word is compared with an in-bench prediction of
// the average, the dip state and the window, or with a typed row's own word.
// ----------------------------------------------------------------------------
module windowed_dip_counter_ema_test;
    import wdc_pkg::*;

    localparam int WINDOW_LIMIT       = 4096;
    localparam int END_SLOTS          = 2048;
    localparam int RANDOM_PHASES      = 8;
    localparam int PHASE_SAMPLES      = 100;
    localparam int SATURATION_PAIRS   = 120;
    localparam int LEAD_PAIRS         = 20;
    localparam int MAX_REPORTS        = 10;

    typedef struct packed {
        logic [11:0] dips;
        logic [31:0] average;
        logic        started;
        logic        tracking;
        logic [12:0] fill;
        logic [47:0] total;
    } light_result_t;

    typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [12:0]   len;
        logic [15:0]   drop;
        logic [15:0]   rise;
        logic [20:0]   weight;
        logic [11:0]   smp;
        logic          typed;
        light_result_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_HISTORY_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [11:0]            sample_value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [11:0]            dip_count;
    logic [31:0]            average_value;
    logic                   dip_started;
    logic                   in_dip;
    logic [12:0]            samples_in_window;
    logic [47:0]            samples_total;

    logic [12:0] ring_cfg   = HISTORY_SIZE_RESET;
    logic [15:0] drop_cfg   = DIP_DROP_RESET;
    logic [15:0] rise_cfg   = RECOVER_RISE_RESET;
    logic [20:0] weight_cfg = EMA_WEIGHT_RESET;

    logic [31:0] ema_q = '0;
    logic        tracking_dip = 1'b0;
    logic [31:0] dip_base = '0;
    logic [11:0] dips_open = '0;
    logic [11:0] slot_pos = '0;
    logic [12:0] fill_cnt = '0;
    logic [47:0] taken_cnt = '0;
    logic [11:0] end_slots [END_SLOTS];
    logic [10:0] end_rd = '0;
    logic [10:0] end_wr = '0;
    logic [11:0] end_cnt = '0;

    light_result_t expected_results [$];
    stim_row_t     directed_rows [$];
    idle_mode_t    idle_mode = IDLE_NONE;
    int            fault_count = 0;

    windowed_dip_counter_ema i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_value      (sample_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .dip_count         (dip_count),
        .average_value     (average_value),
        .dip_started       (dip_started),
        .in_dip            (in_dip),
        .samples_in_window (samples_in_window),
        .samples_total     (samples_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit sender_idles();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_SENDER && roll < 85) || (idle_mode == IDLE_BOTH && roll < 13);
    endfunction

    function automatic bit receiver_stalls();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_RECEIVER && roll < 85) || (idle_mode == IDLE_BOTH && roll < 13);
    endfunction

    function automatic void store_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_HISTORY_SIZE: ring_cfg = val[12:0];
            CFG_DIP_DROP:     drop_cfg = val[15:0];
            CFG_RECOVER_RISE: rise_cfg = val[15:0];
            CFG_EMA_WEIGHT:   weight_cfg = val;
            default: ;
        endcase
    endfunction

    // Advances the predicted state by one sample and returns the result word.
    function automatic light_result_t advance_sample(input logic [11:0] smp);
        int unsigned     ring;
        longint signed   level;
        longint signed   avg_l;
        longint signed   base_l;
        longint signed   drop_l;
        longint signed   rise_l;
        longint unsigned weight;
        longint unsigned blend;
        logic            seeding;
        light_result_t   res;
        ring = (ring_cfg == 0) ? 1 : ((ring_cfg > WINDOW_LIMIT) ? WINDOW_LIMIT : ring_cfg);
        level = {32'd0, smp, 20'd0};
        seeding = (taken_cnt == 0);
        res = '0;

        slot_pos = (slot_pos + 1 >= ring) ? 12'd0 : slot_pos + 12'd1;
        fill_cnt = (fill_cnt + 1 > ring) ? 13'(ring) : fill_cnt + 13'd1;
        if (taken_cnt != TOTAL_MAX)
            taken_cnt = taken_cnt + 48'd1;

        if (end_cnt != 0 && end_slots[end_rd] == slot_pos)
        begin
            end_rd = end_rd + 11'd1;
            end_cnt = end_cnt - 12'd1;
            if (dips_open != 0)
                dips_open = dips_open - 12'd1;
        end

        avg_l = {32'd0, ema_q};
        base_l = {32'd0, dip_base};
        drop_l = {32'd0, drop_cfg, 16'd0};
        rise_l = {32'd0, rise_cfg, 16'd0};
        if (!tracking_dip)
        begin
            if (avg_l - level >= drop_l)
            begin
                tracking_dip = 1'b1;
                dip_base = ema_q;
                res.started = 1'b1;
                if (dips_open < END_SLOTS)
                    dips_open = dips_open + 12'd1;
            end
        end
        else if (level - base_l >= rise_l)
        begin
            tracking_dip = 1'b0;
            if (end_cnt < END_SLOTS)
            begin
                end_slots[end_wr] = slot_pos;
                end_wr = end_wr + 11'd1;
                end_cnt = end_cnt + 12'd1;
            end
        end

        if (seeding)
            ema_q = {smp, 20'd0};
        else
        begin
            weight = (weight_cfg > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight_cfg);
            blend = {32'd0, ema_q} * ((64'd1 << 20) - weight)
                  + {32'd0, smp, 20'd0} * weight + 64'(ROUND_HALF);
            ema_q = blend[51:20];
        end

        res.dips = dips_open;
        res.average = ema_q;
        res.tracking = tracking_dip;
        res.fill = fill_cnt;
        res.total = taken_cnt;
        return res;
    endfunction

    task automatic push_sample(input logic [11:0] smp, input logic typed,
                               input light_result_t want);
        light_result_t predicted;
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_sample(smp);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [12:0] len, input logic [15:0] drop,
                                input logic [15:0] rise, input logic [20:0] weight);
        logic [CFG_INDEX_W-1:0] reg_idx [4];
        logic [CFG_DATA_W-1:0]  reg_val [4];
        int                     k;
        wait_idle();
        reg_idx[0] = CFG_HISTORY_SIZE;
        reg_idx[1] = CFG_DIP_DROP;
        reg_idx[2] = CFG_RECOVER_RISE;
        reg_idx[3] = CFG_EMA_WEIGHT;
        reg_val[0] = {8'd0, len};
        reg_val[1] = {5'd0, drop};
        reg_val[2] = {5'd0, rise};
        reg_val[3] = weight;
        for (k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[k];
            cfg_data <= reg_val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            store_register(reg_idx[k], reg_val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_regs(input logic [12:0] len, input logic [15:0] drop,
                                     input logic [15:0] rise, input logic [20:0] weight);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.len = len;
        row.drop = drop;
        row.rise = rise;
        row.weight = weight;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [11:0] smp);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.smp = smp;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic [11:0] smp, input logic [11:0] dips,
                                      input logic [31:0] average, input logic started,
                                      input logic tracking, input logic [12:0] fill,
                                      input logic [47:0] total);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.smp = smp;
        row.typed = 1'b1;
        row.want.dips = dips;
        row.want.average = average;
        row.want.started = started;
        row.want.tracking = tracking;
        row.want.fill = fill;
        row.want.total = total;
        directed_rows.push_back(row);
    endfunction

    // The first sample seeds the average; then a dip opens, recovers, and a
    // second one opens. Later rows cover the clamped ring length and weight,
    // an average that falls back to zero, and thresholds that can never trip.
    task automatic load_directed();
        add_known(12'd2048, 12'd0, 32'h8000_0000, 1'b0, 1'b0, 13'd1, 48'd1);
        add_sample(12'd0);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd1000);
        add_sample(12'd2100);
        add_sample(12'd4095);
        add_regs(13'd0, 16'd0, 16'd0, 21'h1F_FFFF);
        add_sample(12'd0);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd1);
        add_sample(12'd4094);
        add_regs(13'h1FFF, 16'hFFFF, 16'hFFFF, 21'd0);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_sample(12'd2730);
        add_regs(13'd4096, 16'h8000, 16'd0, 21'h8_0000);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_regs(HISTORY_SIZE_RESET, DIP_DROP_RESET, RECOVER_RISE_RESET, EMA_WEIGHT_RESET);
    endtask

    task automatic randomize_regs();
        logic [12:0] len;
        logic [15:0] drop;
        logic [15:0] rise;
        logic [20:0] weight;
        case ($urandom_range(9))
            0: len = 13'd0;
            1: len = 13'd1;
            2: len = 13'd4096;
            3: len = 13'h1FFF;
            4: len = 13'd4097;
            5, 6, 7: len = 13'($urandom_range(64, 2));
            default: len = 13'($urandom_range(1500, 65));
        endcase
        case ($urandom_range(9))
            0: drop = 16'd0;
            1: drop = 16'hFFFF;
            2: drop = 16'($urandom_range(65535));
            default: drop = 16'($urandom_range(8000, 200));
        endcase
        case ($urandom_range(9))
            0: rise = 16'd0;
            1: rise = 16'hFFFF;
            2: rise = 16'($urandom_range(65535));
            default: rise = 16'($urandom_range(4000, 100));
        endcase
        case ($urandom_range(9))
            0: weight = 21'd0;
            1: weight = WEIGHT_ONE;
            2: weight = 21'h1F_FFFF;
            3: weight = 21'($urandom_range(2097151));
            default: weight = 21'($urandom_range(400000, 2000));
        endcase
        program_regs(len, drop, rise, weight);
    endtask

    // Mostly dip episodes around a wandering light level: a steady stretch,
    // a drop, a short hold and a recovery, with raw noise mixed in.
    task automatic run_random_phase(input int count);
        int base;
        int depth;
        int rise;
        int steps;
        int level;
        int left;
        int k;
        int episode [$];
        base = $urandom_range(4095, 300);
        left = count;
        while (left > 0)
        begin
            episode.delete();
            if ($urandom_range(9) < 3)
                episode.push_back($urandom_range(4095));
            else
            begin
                if ($urandom_range(4) == 0)
                    base = $urandom_range(4095, 300);
                steps = $urandom_range(6, 1);
                for (k = 0; k < steps; k++)
                    episode.push_back(base + $urandom_range(20) - 10);
                depth = $urandom_range(1200);
                steps = $urandom_range(3, 1);
                for (k = 0; k < steps; k++)
                    episode.push_back(base - depth + $urandom_range(20) - 10);
                rise = $urandom_range(400);
                steps = $urandom_range(2, 1);
                for (k = 0; k < steps; k++)
                    episode.push_back(base + rise);
            end
            while (left > 0 && episode.size() != 0)
            begin
                level = episode.pop_front();
                level = (level < 0) ? 0 : ((level > 4095) ? 4095 : level);
                push_sample(12'(level), 1'b0, '0);
                left--;
            end
        end
    endtask

    // With a zero weight and zero thresholds each zero/high pair is one dip.
    // Shrinking the ring below the slot held at the queue head stops all
    // retirement, so the dip counter and the end queue only grow.
    task automatic run_saturation();
        int guard;
        int k;
        program_regs(13'd4096, 16'd0, 16'd0, 21'd0);
        guard = 0;
        while (!(end_cnt != 0 && end_slots[end_rd] >= 2) && guard < LEAD_PAIRS)
        begin
            push_sample(12'd0, 1'b0, '0);
            push_sample(12'd4095, 1'b0, '0);
            guard++;
        end
        program_regs(13'd2, 16'd0, 16'd0, 21'd0);
        for (k = 0; k < SATURATION_PAIRS; k++)
        begin
            push_sample(($urandom_range(15) == 0) ? 12'($urandom_range(4095)) : 12'd0,
                        1'b0, '0);
            push_sample(12'd4095, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        light_result_t got;
        light_result_t want;
        got.dips = dip_count;
        got.average = average_value;
        got.started = dip_started;
        got.tracking = in_dip;
        got.fill = samples_in_window;
        got.total = samples_total;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected: dips=%0d avg=%h",
                             $time, got.dips, got.average);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.dips !== want.dips || got.average !== want.average
                    || got.started !== want.started || got.tracking !== want.tracking
                    || got.fill !== want.fill || got.total !== want.total)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp dips=%0d avg=%h st=%b in=%b win=%0d tot=%0d %s",
                                 $time, want.dips, want.average, want.started, want.tracking,
                                 want.fill, want.total, "");
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t:          got dips=%0d avg=%h st=%b in=%b win=%0d tot=%0d",
                                 $time, got.dips, got.average, got.started, got.tracking,
                                 got.fill, got.total);
                end
            end
        end
        out_stall <= receiver_stalls();
    end

    initial
    begin
        int phase;
        stim_row_t row;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_directed();
        idle_mode = IDLE_NONE;
        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            if (row.kind == ROW_CONFIG)
                program_regs(row.len, row.drop, row.rise, row.weight);
            else
                push_sample(row.smp, row.typed, row.want);
        end
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            randomize_regs();
            run_random_phase(PHASE_SAMPLES);
            if (phase == 3)
                run_saturation();
        end
        wait_idle();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
